// ===== rtl/rmcu_pkg.sv =====
package rmcu_pkg;

	localparam int DIMENSION_DEF  = 4;
	localparam int COUNT_BITS_DEF = 24;
	localparam int VAL_W          = 64;
	localparam int MUL_W          = 32;
	localparam int DIV_W          = 49;
	localparam int ACC_W          = 97;
	localparam int D_W            = 33;

	localparam logic [2:0] OP_ADD  = 3'd0;
	localparam logic [2:0] OP_REM  = 3'd1;
	localparam logic [2:0] OP_ADDV = 3'd2;
	localparam logic [2:0] OP_REMV = 3'd3;
	localparam logic [2:0] OP_READ = 3'd4;

	localparam logic [1:0] KIND_STAT = 2'd0;
	localparam logic [1:0] KIND_MEAN = 2'd1;
	localparam logic [1:0] KIND_COV  = 2'd2;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] point_0;
		logic signed [31:0] point_1;
		logic signed [31:0] point_2;
		logic signed [31:0] point_3;
		logic [30:0]        var_0;
		logic [30:0]        var_1;
		logic [30:0]        var_2;
		logic [30:0]        var_3;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [1:0]         row;
		logic [1:0]         col;
		logic signed [63:0] value;
		logic [23:0]        count;
		logic               cleared;
		logic               overflow;
		logic               last;
	} res_t;

	function automatic logic signed [31:0] pick_point(cmd_t c, int idx);
		logic signed [31:0] r;
		case (idx)
			0: r = c.point_0;
			1: r = c.point_1;
			2: r = c.point_2;
			3: r = c.point_3;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [30:0] pick_var(cmd_t c, int idx);
		logic [30:0] r;
		case (idx)
			0: r = c.var_0;
			1: r = c.var_1;
			2: r = c.var_2;
			3: r = c.var_3;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [63:0] mag64(logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic signed [63:0] from_mag(logic neg, logic [63:0] m);
		logic signed [63:0] r;
		if (!neg)
			r = m[63] ? 64'sh7FFF_FFFF_FFFF_FFFF : $signed(m);
		else if (m[63])
			r = 64'sh8000_0000_0000_0000;
		else
			r = -$signed(m);
		return r;
	endfunction

	function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
			logic signed [63:0] b);
		logic signed [64:0] s;
		logic signed [63:0] r;
		s = 65'(a) + 65'(b);
		if (s[64] != s[63])
			r = s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
		else
			r = s[63:0];
		return r;
	endfunction

endpackage

// ===== rtl/running_mean_covariance_update_unit.sv =====
// Running mean and population covariance of DIMENSION-element Q16.16 points.
// Each lane owns one covariance row and runs its multiply-divides one after
// another on its own shift-add/restoring-divide unit. One multiply-divide runs
// a start step, a shift-add multiply over the multiplier bits, a rounding step,
// a restoring division over the accumulator bits and the done hand-off. A row
// element takes four of them plus a write step, and the lanes run side by side.
// The status word of an add or remove shows up once every lane has written its
// row and updated its mean. A variance adds one more multiply-divide. Unknown
// ops and refused or clearing updates give their status word in the next
// cycle. A read streams DIMENSION mean words then DIMENSION^2 covariance
// words, one per cycle, once the unit has entered its read state. The receiver
// cannot stall: each result word is shown for one cycle with done high.
module running_mean_covariance_update_unit import rmcu_pkg::*; #(
	parameter int DIMENSION  = DIMENSION_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  cmd_t cmd,
	output logic busy,
	output logic done,
	output res_t result
);

	localparam int JW = (DIMENSION > 1) ? $clog2(DIMENSION) : 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_READ = 2'd2;

	logic [1:0]            st_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [COUNT_BITS:0]   den_q;
	logic                  add_q, var_q;
	logic signed [D_W-1:0] d_q [DIMENSION];
	logic [30:0]           vr_q [DIMENSION];
	logic                  rd_cov_q;
	logic [JW-1:0]         r_q, c_q;
	logic                  accept, is_add, is_rem, full, clr;
	logic [DIMENSION-1:0]  lane_busy;
	logic signed [31:0]    mean_all [DIMENSION];
	logic signed [63:0]    cov_all [DIMENSION][DIMENSION];
	logic [31:0]           cnt32;
	logic                  rd_last;
	res_t                  stat_w;

	assign accept = start && !busy;
	assign busy   = st_q != S_IDLE;
	assign is_add = cmd.op == OP_ADD || cmd.op == OP_ADDV;
	assign is_rem = cmd.op == OP_REM || cmd.op == OP_REMV;
	assign full   = &cnt_q;
	assign clr    = accept && is_rem && cnt_q <= COUNT_BITS'(1);
	assign cnt32  = 32'(cnt_q);
	assign rd_last = rd_cov_q && int'(r_q) == DIMENSION - 1 &&
		int'(c_q) == DIMENSION - 1;

	// status word for the item at the input
	always_comb begin
		stat_w = '0;
		stat_w.kind = KIND_STAT;
		stat_w.last = 1'b1;
		stat_w.count = cnt32[23:0];
		if (is_add && full) begin
			stat_w.overflow = 1'b1;
		end else if (is_rem && cnt_q <= COUNT_BITS'(1)) begin
			stat_w.count = '0;
			stat_w.cleared = 1'b1;
		end
	end

	for (genvar i = 0; i < DIMENSION; i++) begin : g_lane
		rmcu_lane #(.DIMENSION(DIMENSION), .LANE(i)) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (st_q == S_IDLE && accept && ((is_add && !full) ||
				(is_rem && cnt_q > COUNT_BITS'(1)))),
			.clr      (clr),
			.add      (add_q),
			.with_var (var_q),
			.n        (MUL_W'(cnt_q)),
			.den      (DIV_W'(den_q)),
			.d        (d_q),
			.var_i    (vr_q[i]),
			.busy     (lane_busy[i]),
			.mean     (mean_all[i]),
			.cov      (cov_all[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_IDLE;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (accept) begin
						result <= stat_w;
						if (cmd.op == OP_READ) begin
							rd_cov_q <= 1'b0;
							r_q      <= '0;
							c_q      <= '0;
							st_q     <= S_READ;
						end else if (is_add && full) begin
							done <= 1'b1;
						end else if (clr) begin
							cnt_q <= '0;
							done <= 1'b1;
						end else if (is_add || is_rem) begin
							add_q <= is_add;
							var_q <= cmd.op == OP_ADDV || cmd.op == OP_REMV;
							den_q <= is_add ? {1'b0, cnt_q} + 1'b1
								: {1'b0, cnt_q} - 1'b1;
							for (int k = 0; k < DIMENSION; k++) begin
								d_q[k]  <= D_W'(pick_point(cmd, k)) - D_W'(mean_all[k]);
								vr_q[k] <= pick_var(cmd, k);
							end
							st_q <= S_RUN;
						end else begin
							done <= 1'b1;
						end
					end
				end
				S_RUN: begin
					if (lane_busy == '0) begin
						cnt_q <= den_q[COUNT_BITS-1:0];
						result.count <= 24'(32'(den_q[COUNT_BITS-1:0]));
						done <= 1'b1;
						st_q <= S_IDLE;
					end
				end
				S_READ: begin
					done <= 1'b1;
					result.cleared  <= 1'b0;
					result.overflow <= 1'b0;
					result.count    <= cnt32[23:0];
					result.row      <= 2'(r_q);
					if (!rd_cov_q) begin
						result.kind  <= KIND_MEAN;
						result.col   <= '0;
						result.value <= 64'(mean_all[r_q]);
						result.last  <= 1'b0;
						if (int'(r_q) == DIMENSION - 1) begin
							r_q      <= '0;
							rd_cov_q <= 1'b1;
						end else begin
							r_q <= r_q + JW'(1);
						end
					end else begin
						result.kind  <= KIND_COV;
						result.col   <= 2'(c_q);
						result.value <= cov_all[r_q][c_q];
						result.last  <= rd_last;
						if (int'(c_q) == DIMENSION - 1) begin
							c_q <= '0;
							r_q <= r_q + JW'(1);
						end else begin
							c_q <= c_q + JW'(1);
						end
						if (rd_last)
							st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/rmcu_muldiv.sv =====
module rmcu_muldiv import rmcu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [VAL_W-1:0]   m,
	input  logic [MUL_W-1:0]   mul,
	input  logic [DIV_W-1:0]   div,
	output logic               done,
	output logic [VAL_W-1:0]   q
);

	localparam logic [1:0] M_IDLE = 2'd0;
	localparam logic [1:0] M_MUL  = 2'd1;
	localparam logic [1:0] M_RND  = 2'd2;
	localparam logic [1:0] M_DIV  = 2'd3;

	logic [1:0]       st_q;
	logic [6:0]       cnt_q;
	logic [VAL_W-1:0] m_q;
	logic [MUL_W-1:0] mul_q;
	logic [DIV_W-1:0] div_q;
	logic [ACC_W-1:0] acc_q;
	logic [DIV_W:0]   rem_q;
	logic [VAL_W-1:0] quo_q;
	logic             ovf_q;
	logic [DIV_W:0]   rem_next;
	logic [DIV_W:0]   rem_sub;
	logic             ge;

	assign rem_next = {rem_q[DIV_W-1:0], acc_q[ACC_W-1]};
	assign ge       = rem_next >= {1'b0, div_q};
	assign rem_sub  = rem_next - {1'b0, div_q};
	assign q        = ovf_q ? '1 : quo_q;

	// product by shift-add, then +div/2 for rounding, then restoring division
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= M_IDLE;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			case (st_q)
				M_IDLE: begin
					if (start) begin
						m_q   <= m;
						mul_q <= mul;
						div_q <= div;
						acc_q <= '0;
						cnt_q <= '0;
						st_q  <= M_MUL;
					end
				end
				M_MUL: begin
					acc_q <= {acc_q[ACC_W-2:0], 1'b0} +
						(mul_q[MUL_W-1] ? ACC_W'(m_q) : ACC_W'(0));
					mul_q <= {mul_q[MUL_W-2:0], 1'b0};
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'(MUL_W - 1))
						st_q <= M_RND;
				end
				M_RND: begin
					acc_q <= acc_q + ACC_W'(div_q >> 1);
					rem_q <= '0;
					quo_q <= '0;
					ovf_q <= 1'b0;
					cnt_q <= '0;
					st_q  <= M_DIV;
				end
				M_DIV: begin
					acc_q <= {acc_q[ACC_W-2:0], 1'b0};
					rem_q <= ge ? rem_sub : rem_next;
					quo_q <= {quo_q[VAL_W-2:0], ge};
					ovf_q <= ovf_q | quo_q[VAL_W-1];
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'(ACC_W - 1)) begin
						st_q <= M_IDLE;
						done <= 1'b1;
					end
				end
				default: st_q <= M_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/rmcu_lane.sv =====
module rmcu_lane import rmcu_pkg::*; #(
	parameter int DIMENSION = DIMENSION_DEF,
	parameter int LANE      = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  clr,
	input  logic                  add,
	input  logic                  with_var,
	input  logic [MUL_W-1:0]      n,
	input  logic [DIV_W-1:0]      den,
	input  logic signed [D_W-1:0] d [DIMENSION],
	input  logic [30:0]           var_i,
	output logic                  busy,
	output logic signed [31:0]    mean,
	output logic signed [63:0]    cov [DIMENSION]
);

	localparam int JW = (DIMENSION > 1) ? $clog2(DIMENSION) : 1;

	localparam logic [3:0] L_IDLE = 4'd0;
	localparam logic [3:0] L_C    = 4'd1;
	localparam logic [3:0] L_P    = 4'd2;
	localparam logic [3:0] L_T    = 4'd3;
	localparam logic [3:0] L_Q    = 4'd4;
	localparam logic [3:0] L_V    = 4'd5;
	localparam logic [3:0] L_WR   = 4'd6;
	localparam logic [3:0] L_M    = 4'd7;

	logic [3:0]         st_q;
	logic [JW-1:0]      j_q;
	logic               go_q;
	logic signed [63:0] acc_q;
	logic [63:0]        tmp_q;
	logic [63:0]        md_m;
	logic [MUL_W-1:0]   md_mul;
	logic [DIV_W-1:0]   md_div;
	logic               md_done;
	logic [63:0]        md_q;
	logic signed [D_W-1:0] di, dj;
	logic [63:0]        mag_i, mag_j;
	logic signed [63:0] cur_c;
	logic signed [33:0] mean_sum;
	logic signed [63:0] step;

	assign di    = d[LANE];
	assign dj    = d[j_q];
	assign mag_i = mag64(64'(di));
	assign mag_j = mag64(64'(dj));
	assign cur_c = cov[j_q];
	assign busy  = st_q != L_IDLE;
	assign step  = from_mag(di[D_W-1] != !add, md_q);
	assign mean_sum = 34'(mean) + 34'(step);

	always_comb begin
		md_m   = tmp_q;
		md_mul = MUL_W'(1);
		md_div = den;
		case (st_q)
			L_C: begin
				md_m   = mag64(cur_c);
				md_mul = n;
			end
			L_P: begin
				md_m   = mag_i;
				md_mul = mag_j[MUL_W-1:0];
				md_div = DIV_W'(1);
			end
			L_T: begin
				md_mul = n;
				md_div = den << 16;
			end
			L_V:     md_m = 64'(var_i);
			L_M:     md_m = mag_i;
			default: md_m = tmp_q;
		endcase
	end

	rmcu_muldiv u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (go_q),
		.m      (md_m),
		.mul    (md_mul),
		.div    (md_div),
		.done   (md_done),
		.q      (md_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= L_IDLE;
			j_q  <= '0;
			go_q <= 1'b0;
			mean <= '0;
			for (int k = 0; k < DIMENSION; k++)
				cov[k] <= '0;
		end else begin
			go_q <= 1'b0;
			if (clr) begin
				mean <= '0;
				for (int k = 0; k < DIMENSION; k++)
					cov[k] <= '0;
			end
			case (st_q)
				L_IDLE: begin
					if (start) begin
						j_q  <= '0;
						go_q <= 1'b1;
						st_q <= L_C;
					end
				end
				L_C: begin
					if (md_done) begin
						acc_q <= from_mag(cur_c[63], md_q);
						go_q  <= 1'b1;
						st_q  <= L_P;
					end
				end
				L_P: begin
					if (md_done) begin
						tmp_q <= md_q;
						go_q  <= 1'b1;
						st_q  <= L_T;
					end
				end
				L_T: begin
					if (md_done) begin
						tmp_q <= md_q;
						go_q  <= 1'b1;
						st_q  <= L_Q;
					end
				end
				L_Q: begin
					if (md_done) begin
						acc_q <= sat_add(acc_q,
							from_mag((di[D_W-1] != dj[D_W-1]) != !add, md_q));
						if (with_var && int'(j_q) == LANE) begin
							go_q <= 1'b1;
							st_q <= L_V;
						end else begin
							st_q <= L_WR;
						end
					end
				end
				L_V: begin
					if (md_done) begin
						acc_q <= sat_add(acc_q, from_mag(!add, md_q));
						st_q  <= L_WR;
					end
				end
				L_WR: begin
					cov[j_q] <= acc_q;
					go_q     <= 1'b1;
					if (int'(j_q) == DIMENSION - 1) begin
						st_q <= L_M;
					end else begin
						j_q  <= j_q + JW'(1);
						st_q <= L_C;
					end
				end
				L_M: begin
					if (md_done) begin
						if (mean_sum > 34'sd2147483647)
							mean <= 32'sh7FFF_FFFF;
						else if (mean_sum < -34'sd2147483648)
							mean <= 32'sh8000_0000;
						else
							mean <= mean_sum[31:0];
						st_q <= L_IDLE;
					end
				end
				default: st_q <= L_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/rmcu_chk.sv =====
module rmcu_chk import rmcu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input cmd_t cmd,
	input logic busy,
	input logic done,
	input res_t result
);

	// status words carry no element
	a_stat_shape: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.kind == KIND_STAT |->
			result.last && result.row == 2'd0 && result.col == 2'd0 &&
			result.value == 64'sd0)
		else $error("status word has element fields");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.cleared && result.overflow))
		else $error("cleared and overflow together");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.op == OP_READ |=> busy)
		else $error("read did not hold busy");

	a_cleared_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.cleared |-> result.count == 24'd0)
		else $error("cleared with nonzero count");

endmodule

bind running_mean_covariance_update_unit rmcu_chk u_rmcu_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.cmd    (cmd),
	.busy   (busy),
	.done   (done),
	.result (result)
);
